[src/rasst_pkg.sv]
// ----------------------------------------------------------------------------
// rasst_pkg: shared definitions for the range add / range sum store
// Widths, command codes, reset size and the sequencer state type.
// ----------------------------------------------------------------------------
package rasst_pkg;

  localparam int DATA_W               = 64;
  localparam int IDX_W                = 10;
  localparam int SIZE_W               = 11;
  localparam int DEFAULT_MAX_ELEMENTS = 1024;
  localparam int SIZE_RESET           = 1024;

  localparam logic CMD_ADD   = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  // one entry of the two prefix-sum trees, kept side by side in one word
  typedef struct packed {
    logic [DATA_W-1:0] b1;
    logic [DATA_W-1:0] b2;
  } fw_word_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UMUL,
    ST_URD,
    ST_UWR,
    ST_QRD,
    ST_QACC,
    ST_QMUL,
    ST_QSUB,
    ST_QFIN
  } state_t;

endpackage

[src/range_add_range_sum_tree_core.sv]
// ----------------------------------------------------------------------------
// range_add_range_sum_tree_core: range add / range sum over a signed array
// Fenwick-pair store walked by a small sequencer with shared multiplier operands.
// ----------------------------------------------------------------------------
// Keeps size_in_use signed 64-bit elements (zero after reset and after every
// write of cfg_data) and serves two commands: add add_value over the inclusive
// range [range_low, range_high], or return the sum over that range, mod 2^64.
// Indices at or past the size in use are clipped; an empty range adds nothing
// and a query on it returns 0. A command transfer happens on a clock edge with
// start high and busy low. A query's result appears on range_sum for exactly
// one cycle with result_valid high; there is no back-pressure, so the receiver
// must take it then. An add gives no result.
// Walk: the array lives as two Fenwick trees packed in one RAM word. Each
// tree node visited costs one RAM read plus one write (add) or accumulate
// (query), and the single RAM port pair sets the rate. With L equal to
// ceil(log2(size+1)) an add takes one multiply step per edge, at most L
// nodes on the left edge and L-1 on the right, and a query up to two prefix
// walks, each followed by three finishing steps (QMUL, QSUB, QFIN). An empty
// range never raises busy. After reset and after each cfg_data write the RAM
// is swept to zero, one entry per cycle over all MAX_ELEMENTS entries, with
// busy high.
// ----------------------------------------------------------------------------
module range_add_range_sum_tree_core #(
  parameter int MAX_ELEMENTS = rasst_pkg::DEFAULT_MAX_ELEMENTS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 command,
  input  logic [rasst_pkg::IDX_W-1:0]          range_low,
  input  logic [rasst_pkg::IDX_W-1:0]          range_high,
  input  logic signed [rasst_pkg::DATA_W-1:0]  add_value,
  output logic signed [rasst_pkg::DATA_W-1:0]  range_sum,
  output logic                                 result_valid,
  input  logic                                 cfg_write,
  input  logic [rasst_pkg::SIZE_W-1:0]         cfg_data
);

  localparam int DW = rasst_pkg::DATA_W;
  localparam int PW = $clog2(MAX_ELEMENTS + 1);   // holds 0..MAX_ELEMENTS
  localparam int NW = PW + 1;                      // walk position, may overshoot
  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int EW = (PW > rasst_pkg::SIZE_W) ? PW : rasst_pkg::SIZE_W;
  localparam int RESET_N = (rasst_pkg::SIZE_RESET > MAX_ELEMENTS) ?
                           MAX_ELEMENTS : rasst_pkg::SIZE_RESET;

  rasst_pkg::state_t state, state_next;

  // control registers
  logic [PW-1:0] n_act;      // active size, 1..MAX_ELEMENTS
  logic [AW-1:0] clr_addr;
  logic          phase;      // add: 0 = left edge, 1 = right edge; query: 0 = P(r), 1 = P(a)

  // datapath registers
  logic          cmd_q;
  logic [PW-1:0] a_q;        // zero-based low index, also 1-based (l-1)
  logic [PW-1:0] r_q;        // 1-based clipped high index
  logic [DW-1:0] v_q;
  logic [NW-1:0] pos;
  logic [DW-1:0] d1, d2;
  logic [DW-1:0] acc1, acc2;
  logic [DW-1:0] prod;
  logic [DW-1:0] pval;
  logic [DW-1:0] part;

  // RAM
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  rasst_pkg::fw_word_t  ram_wdata, ram_rdata;

  rasst_ram #(
    .WIDTH ($bits(rasst_pkg::fw_word_t)),
    .DEPTH (MAX_ELEMENTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // command decode and clipping
  logic          accept;
  logic [EW-1:0] a_ext, b_ext, n_ext, hi_clip, size_ext, size_clip;
  logic          empty;

  assign accept = start && !busy;
  assign a_ext  = EW'(range_low);
  assign b_ext  = EW'(range_high);
  assign n_ext  = EW'(n_act);
  assign hi_clip = (b_ext >= n_ext) ? (n_ext - EW'(1)) : b_ext;
  assign empty  = (a_ext > b_ext) || (a_ext >= n_ext);

  assign size_ext  = EW'(cfg_data);
  assign size_clip = (size_ext == '0) ? EW'(1) :
                     (size_ext > EW'(MAX_ELEMENTS)) ? EW'(MAX_ELEMENTS) : size_ext;

  // Fenwick walk: lowest set bit of the position
  logic [NW-1:0] low_bit, pos_up, pos_dn;
  logic          up_done, last_edge;

  assign low_bit   = pos & (~pos + NW'(1));
  assign pos_up    = pos + low_bit;
  assign pos_dn    = pos - low_bit;
  assign up_done   = pos_up > NW'(n_act);
  assign last_edge = phase || (r_q >= n_act);   // no right edge past the end

  // multiplier operands: left edge wants v*(l-1), right edge v*r,
  // query wants acc1*r for P(r) and acc1*a for P(a)
  logic [DW-1:0] mul_a;
  logic [PW-1:0] mul_b;
  assign mul_a = (state == rasst_pkg::ST_QMUL) ? acc1 : v_q;
  assign mul_b = (state == rasst_pkg::ST_QMUL) ? (phase ? a_q : r_q)
                                               : (phase ? r_q : a_q);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      rasst_pkg::ST_CLEAR:
        if (clr_addr == AW'(MAX_ELEMENTS - 1)) state_next = rasst_pkg::ST_IDLE;
      rasst_pkg::ST_IDLE:
        if (accept && !empty) begin
          state_next = (command == rasst_pkg::CMD_ADD) ? rasst_pkg::ST_UMUL
                                                       : rasst_pkg::ST_QRD;
        end
      rasst_pkg::ST_UMUL: state_next = rasst_pkg::ST_URD;
      rasst_pkg::ST_URD:  state_next = rasst_pkg::ST_UWR;
      rasst_pkg::ST_UWR: begin
        if (!up_done)       state_next = rasst_pkg::ST_URD;
        else if (last_edge) state_next = rasst_pkg::ST_IDLE;
        else                state_next = rasst_pkg::ST_UMUL;
      end
      rasst_pkg::ST_QRD:  state_next = rasst_pkg::ST_QACC;
      rasst_pkg::ST_QACC:
        state_next = (pos_dn == '0) ? rasst_pkg::ST_QMUL : rasst_pkg::ST_QRD;
      rasst_pkg::ST_QMUL: state_next = rasst_pkg::ST_QSUB;
      rasst_pkg::ST_QSUB: state_next = rasst_pkg::ST_QFIN;
      rasst_pkg::ST_QFIN:
        state_next = (!phase && a_q != '0) ? rasst_pkg::ST_QRD : rasst_pkg::ST_IDLE;
      default: state_next = rasst_pkg::ST_IDLE;
    endcase
    if (cfg_write) state_next = rasst_pkg::ST_CLEAR;
  end

  // outputs of the sequencer
  always_comb begin
    busy      = (state != rasst_pkg::ST_IDLE);
    ram_we    = 1'b0;
    ram_waddr = AW'(pos - NW'(1));
    ram_raddr = AW'(pos - NW'(1));
    ram_wdata = '0;
    unique case (state)
      rasst_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
      end
      rasst_pkg::ST_UWR: begin
        ram_we       = 1'b1;
        ram_wdata.b1 = ram_rdata.b1 + d1;
        ram_wdata.b2 = ram_rdata.b2 + d2;
      end
      default: ram_we = 1'b0;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= rasst_pkg::ST_CLEAR;
      clr_addr     <= '0;
      n_act        <= PW'(RESET_N);
      result_valid <= 1'b0;
      phase        <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= 1'b0;
      if (cfg_write) begin
        n_act    <= PW'(size_clip);
        clr_addr <= '0;
      end else if (state == rasst_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end
      unique case (state)
        rasst_pkg::ST_IDLE: begin
          phase <= 1'b0;
          if (accept && empty && command == rasst_pkg::CMD_QUERY) result_valid <= 1'b1;
        end
        rasst_pkg::ST_UWR:
          if (up_done && !last_edge) phase <= 1'b1;
        rasst_pkg::ST_QFIN: begin
          if (!phase && a_q != '0) phase <= 1'b1;
          else                     result_valid <= 1'b1;
        end
        default: phase <= phase;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      rasst_pkg::ST_IDLE:
        if (accept) begin
          cmd_q <= command;
          a_q   <= PW'(a_ext);
          r_q   <= PW'(hi_clip + EW'(1));
          v_q   <= add_value;
          d1    <= add_value;
          pos   <= NW'(a_ext + EW'(1));
          acc1  <= '0;
          acc2  <= '0;
          if (command == rasst_pkg::CMD_QUERY) pos <= NW'(hi_clip + EW'(1));
          if (empty) range_sum <= '0;
        end
      rasst_pkg::ST_UMUL: prod <= mul_a * DW'(mul_b);
      rasst_pkg::ST_URD:  d2   <= phase ? (~prod + DW'(1)) : prod;
      rasst_pkg::ST_UWR: begin
        pos <= pos_up;
        if (up_done && !last_edge) begin
          pos <= NW'(r_q) + NW'(1);
          d1  <= ~v_q + DW'(1);
        end
      end
      rasst_pkg::ST_QACC: begin
        acc1 <= acc1 + ram_rdata.b1;
        acc2 <= acc2 + ram_rdata.b2;
        pos  <= pos_dn;
      end
      rasst_pkg::ST_QMUL: prod <= mul_a * DW'(mul_b);
      rasst_pkg::ST_QSUB: pval <= prod - acc2;
      rasst_pkg::ST_QFIN: begin
        if (!phase) begin
          part      <= pval;
          range_sum <= pval;
          pos       <= NW'(a_q);
          acc1      <= '0;
          acc2      <= '0;
        end else begin
          range_sum <= part - pval;
        end
      end
      default: pos <= pos;
    endcase
  end

  // checks
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ($past(state) == rasst_pkg::ST_QFIN) ||
                     ($past(accept) && $past(command) == rasst_pkg::CMD_QUERY))
    else $error("result strobe without a finished query");

  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == rasst_pkg::ST_CLEAR) || (state == rasst_pkg::ST_UWR))
    else $error("RAM write outside clear or update");

  a_upd_pos: assert property (@(posedge clk) disable iff (rst)
    (state == rasst_pkg::ST_URD) |-> (pos != '0) && (pos <= NW'(n_act)) &&
                                     (cmd_q == rasst_pkg::CMD_ADD))
    else $error("update walk outside the tree");

  a_qry_pos: assert property (@(posedge clk) disable iff (rst)
    (state == rasst_pkg::ST_QRD) |-> (pos != '0) && (pos <= NW'(n_act)) &&
                                     (cmd_q == rasst_pkg::CMD_QUERY))
    else $error("query walk outside the tree");

endmodule

[src/rasst_ram.sv]
// ----------------------------------------------------------------------------
// rasst_ram: generic single-write, single-read RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module rasst_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
